// File: design/bmpl_pkg.sv
package bmpl_pkg;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_PAL  = 3'd1,
		PH_SKIP = 3'd2,
		PH_PIX  = 3'd3,
		PH_DONE = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		PM_1BPP = 2'd0,
		PM_2BPP = 2'd1,
		PM_8BPP = 2'd2,
		PM_RGB  = 2'd3
	} pix_mode_t;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NOT_BMP   = 4'd1;
	localparam logic [3:0] ERR_DIB_SMALL = 4'd2;
	localparam logic [3:0] ERR_PLANES    = 4'd3;
	localparam logic [3:0] ERR_BPP       = 4'd4;
	localparam logic [3:0] ERR_COMPRESS  = 4'd5;
	localparam logic [3:0] ERR_PALETTE   = 4'd6;
	localparam logic [3:0] ERR_DIMS      = 4'd7;
	localparam logic [3:0] ERR_TOO_LARGE = 4'd8;
	localparam logic [3:0] ERR_BEHIND    = 4'd9;

	// byte positions at which a little-endian header field is complete
	localparam logic [31:0] POS_SIG     = 32'd1;
	localparam logic [31:0] POS_OFFSET  = 32'd13;
	localparam logic [31:0] POS_DIB     = 32'd17;
	localparam logic [31:0] POS_WIDTH   = 32'd21;
	localparam logic [31:0] POS_HEIGHT  = 32'd25;
	localparam logic [31:0] POS_PLANES  = 32'd27;
	localparam logic [31:0] POS_BPP     = 32'd29;
	localparam logic [31:0] POS_COMPR   = 32'd33;
	localparam logic [31:0] POS_COLORS  = 32'd49;
	localparam logic [31:0] POS_HDR_END = 32'd53;
	localparam logic [31:0] PAL_START   = 32'd54;

	localparam logic [15:0] BMP_MAGIC = 16'h4D42;
	localparam logic [31:0] DIB_MIN   = 32'd40;

	localparam logic REG_MAX_WIDTH  = 1'b0;
	localparam logic REG_MAX_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  err;
		pix_mode_t   mode;
		logic [7:0]  data;
		logic [23:0] rgb;
		logic [3:0]  cnt;
		logic [12:0] xbase;
		logic [12:0] width;
		logic [12:0] height;
		logic [12:0] row;
		logic        last_row;
		logic [5:0]  bpp;
		logic        top;
		logic [2:0]  pc_cap;
		logic        use_pal;
	} item_t;

	function automatic logic [7:0] luma3(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [15:0] s;
		s = 16'd77 * 16'(r) + 16'd150 * 16'(g) + 16'd29 * 16'(b);
		return s[15:8];
	endfunction

endpackage

// File: design/bmp_stream_to_luma_decoder.sv
// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     tdata: data_byte; tuser: first_byte
// m_*       out  m_tvalid / m_tready     tdata: pixel/header/error fields; tuser: kind;
//                                        tlast: last
// APB       in   psel & penable & pwrite paddr 0: max_width, 4: max_height
//
// One byte is taken per cycle while the item register is free. A byte is parsed
// in the cycle it is accepted and its results are held in one item register; a
// 1-bpp byte yields up to eight pixels and a 2-bpp byte up to four, one per
// cycle unless m_tready stalls, each holding the input until the last is out. The
// result register behind the item register lets the next byte enter while a
// result still waits on m_tready. Reset clears the parse state and restores the
// limits to 2048 and 3072; the palette memory is not cleared.
module bmp_stream_to_luma_decoder
	import bmpl_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_DIMENSION   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] lum, [19:8] pixel_x, [31:20] pixel_y, [35:32] error_code,
	// [48:36] image_width, [61:49] image_height, [67:62] bits_per_pixel,
	// [68] top_down, [69] row_end, [70] image_end, [71] zero
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);
	localparam logic [31:0] PAL_MAX = 32'(PALETTE_ENTRIES);

	// configuration
	logic [12:0] max_width_q, max_height_q;

	// parse state
	phase_t      phase_q, n_phase, eff_phase;
	logic [31:0] pos_q, n_pos, eff_pos;
	logic [31:0] fa_q, n_fa, eff_fa, f;
	logic [31:0] off_q, n_off;
	logic [31:0] raw_w_q, n_raw_w, raw_h_q, n_raw_h;
	logic [15:0] raw_bpp_q, n_raw_bpp;
	logic        planes_ok_q, n_planes_ok;
	logic [5:0]  bpp_q, n_bpp;
	logic [12:0] w_q, n_w, h_q, n_h;
	logic        top_q, n_top;
	logic [8:0]  pc_q, n_pc;
	logic [14:0] rowlen_q, n_rowlen;
	logic [14:0] rb_q, n_rb;
	logic [12:0] row_q, n_row;
	logic [14:0] col_q, n_col;
	logic [1:0]  bip_q, n_bip;
	logic [23:0] cb_q, n_cb;

	// palette storage; entries 0..3 are mirrored for the 1/2-bpp lanes
	logic [7:0]    pal_mem [PALETTE_ENTRIES];
	logic [7:0]    lut_q [4];
	logic          pal_we;
	logic [7:0]    pal_widx;
	logic [7:0]    pal_wdata;
	logic [7:0]    pal_rd_s1;

	// item register
	item_t       item, s1_q;
	logic        item_vld, s1_vld_q;
	logic [2:0]  s1_k_q;

	logic        accept, out_load, s1_done;
	logic [7:0]  b;

	// scratch for the parse
	logic        do_err, do_end, do_hdr;
	logic [3:0]  err_code;
	logic [31:0] end_next, hgt_abs, lw, lh, rel;
	logic        vb;
	logic [18:0] bits;
	logic [19:0] bits_r;
	logic [17:0] base1, rem1;
	logic [16:0] base2, rem2;
	logic        bip_last;
	logic [13:0] row_inc;

	assign b        = s_tdata;
	assign pready   = 1'b1;
	assign prdata   = {19'd0, paddr[2] ? max_height_q : max_width_q};
	assign out_load = s1_vld_q && (!m_tvalid || m_tready);
	assign s1_done  = out_load && ({1'b0, s1_k_q} + 4'd1 == s1_q.cnt);
	assign s_tready = !s1_vld_q || s1_done;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		eff_phase = s_tuser[0] ? PH_HDR : phase_q;
		eff_pos   = s_tuser[0] ? 32'd0 : pos_q;
		eff_fa    = s_tuser[0] ? 32'd0 : fa_q;
		f         = {b, eff_fa[31:8]};

		n_phase = eff_phase;  n_fa = eff_fa;   n_off = off_q;
		n_raw_w = raw_w_q;    n_raw_h = raw_h_q; n_raw_bpp = raw_bpp_q;
		n_planes_ok = planes_ok_q; n_bpp = bpp_q; n_w = w_q; n_h = h_q;
		n_top = top_q;        n_pc = pc_q;     n_rowlen = rowlen_q;
		n_rb = rb_q;          n_row = row_q;   n_col = col_q;
		n_bip = bip_q;        n_cb = cb_q;

		item     = '0;
		item_vld = 1'b0;
		do_err   = 1'b0;
		do_end   = 1'b0;
		do_hdr   = 1'b0;
		err_code = ERR_NONE;
		end_next = PAL_START;
		pal_we   = 1'b0;
		pal_widx = '0;
		pal_wdata = luma3(cb_q[23:16], cb_q[15:8], cb_q[7:0]);

		lw      = (32'(max_width_q) > MAX_DIM) ? MAX_DIM : 32'(max_width_q);
		lh      = (32'(max_height_q) > MAX_DIM) ? MAX_DIM : 32'(max_height_q);
		hgt_abs = raw_h_q[31] ? (32'd0 - raw_h_q) : raw_h_q;
		vb      = raw_bpp_q == 16'd1 || raw_bpp_q == 16'd2 || raw_bpp_q == 16'd8 ||
			raw_bpp_q == 16'd24 || raw_bpp_q == 16'd32;
		bits    = 19'(raw_w_q[12:0]) * 19'(bpp_q);
		bits_r  = 20'(bits) + 20'd31;
		rel     = eff_pos - PAL_START;
		base1   = {rb_q, 3'b000};
		rem1    = 18'(w_q) - base1;
		base2   = {rb_q, 2'b00};
		rem2    = 17'(w_q) - base2;
		bip_last = (bpp_q == 6'd32) ? (bip_q == 2'd3) : (bip_q == 2'd2);
		row_inc = 14'(row_q) + 14'd1;

		case (eff_phase)
			PH_HDR: begin
				n_fa = f;
				case (eff_pos)
					POS_SIG: if (f[31:16] != BMP_MAGIC) begin
						do_err = 1'b1; err_code = ERR_NOT_BMP;
					end
					POS_OFFSET: n_off = f;
					POS_DIB: if (f < DIB_MIN) begin
						do_err = 1'b1; err_code = ERR_DIB_SMALL;
					end
					POS_WIDTH:  n_raw_w = f;
					POS_HEIGHT: n_raw_h = f;
					POS_PLANES: n_planes_ok = (f[31:16] == 16'd1);
					POS_BPP:    n_raw_bpp = f[31:16];
					POS_COMPR: begin
						if (!planes_ok_q) begin
							do_err = 1'b1; err_code = ERR_PLANES;
						end else if (!vb) begin
							do_err = 1'b1; err_code = ERR_BPP;
						end else if (!(f == 32'd0 || (raw_bpp_q == 16'd32 && f == 32'd3))) begin
							do_err = 1'b1; err_code = ERR_COMPRESS;
						end else begin
							n_bpp = raw_bpp_q[5:0];
						end
					end
					POS_COLORS: begin
						if (f > PAL_MAX) begin
							do_err = 1'b1; err_code = ERR_PALETTE;
						end else if (raw_w_q == 32'd0 || raw_w_q[31] || hgt_abs == 32'd0 ||
							hgt_abs[31]) begin
							do_err = 1'b1; err_code = ERR_DIMS;
						end else if (raw_w_q > lw || hgt_abs > lh) begin
							do_err = 1'b1; err_code = ERR_TOO_LARGE;
						end else begin
							n_pc     = f[8:0];
							n_w      = raw_w_q[12:0];
							n_h      = hgt_abs[12:0];
							n_top    = raw_h_q[31];
							n_rowlen = {bits_r[17:5], 2'b00};
						end
					end
					POS_HDR_END: begin
						if (pc_q == 9'd0) begin
							do_end = 1'b1; end_next = PAL_START;
						end else begin
							n_phase = PH_PAL;
						end
					end
					default: ;
				endcase
			end
			PH_PAL: begin
				case (rel[1:0])
					2'd0: n_cb[7:0]   = b;
					2'd1: n_cb[15:8]  = b;
					2'd2: n_cb[23:16] = b;
					default: begin
						// commit the entry and look for the end of the palette
						pal_we   = 32'(rel[9:2]) < PAL_MAX;
						pal_widx = rel[9:2];
						if (9'(rel[9:2]) + 9'd1 >= pc_q) begin
							do_end = 1'b1; end_next = eff_pos + 32'd1;
						end
					end
				endcase
			end
			PH_SKIP: if (eff_pos + 32'd1 == off_q) do_hdr = 1'b1;
			PH_PIX: begin
				item.kind     = KIND_PIXEL;
				item.data     = b;
				item.row      = row_q;
				item.width    = w_q;
				item.last_row = (row_inc == 14'(h_q));
				item.pc_cap   = (pc_q >= 9'd4) ? 3'd4 : pc_q[2:0];
				item.use_pal  = {1'b0, b} < pc_q;
				case (bpp_q)
					6'd1: begin
						item.mode = PM_1BPP;
						if (base1 < 18'(w_q)) begin
							item_vld   = 1'b1;
							item.cnt   = (rem1 >= 18'd8) ? 4'd8 : rem1[3:0];
							item.xbase = base1[12:0];
						end
					end
					6'd2: begin
						item.mode = PM_2BPP;
						if (base2 < 17'(w_q)) begin
							item_vld   = 1'b1;
							item.cnt   = (rem2 >= 17'd4) ? 4'd4 : rem2[3:0];
							item.xbase = base2[12:0];
						end
					end
					6'd8: begin
						item.mode = PM_8BPP;
						if (rb_q < 15'(w_q)) begin
							item_vld   = 1'b1;
							item.cnt   = 4'd1;
							item.xbase = rb_q[12:0];
						end
					end
					default: begin
						item.mode = PM_RGB;
						if (col_q < 15'(w_q)) begin
							case (bip_q)
								2'd0: n_cb[7:0]   = b;
								2'd1: n_cb[15:8]  = b;
								2'd2: n_cb[23:16] = b;
								default: ;
							endcase
							if (bip_q == 2'd2) begin
								item_vld   = 1'b1;
								item.cnt   = 4'd1;
								item.xbase = col_q[12:0];
								item.rgb   = {b, cb_q[15:0]};
							end
						end
						// advance the byte-in-pixel and column counters
						if (bip_last) begin
							n_bip = 2'd0;
							n_col = col_q + 15'd1;
						end else begin
							n_bip = bip_q + 2'd1;
						end
					end
				endcase
				n_rb = rb_q + 15'd1;
				if (n_rb >= rowlen_q) begin
					n_rb  = '0;
					n_col = '0;
					n_bip = '0;
					n_row = row_inc[12:0];
					if (row_inc >= 14'(h_q)) n_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		if (do_end) begin
			if (off_q < end_next) begin
				do_err = 1'b1; err_code = ERR_BEHIND;
			end else if (off_q == end_next) begin
				do_hdr = 1'b1;
			end else begin
				n_phase = PH_SKIP;
			end
		end

		if (do_err) begin
			item          = '0;
			item_vld      = 1'b1;
			item.kind     = KIND_ERROR;
			item.err      = err_code;
			item.cnt      = 4'd1;
			n_phase       = PH_ERR;
		end else if (do_hdr) begin
			item          = '0;
			item_vld      = 1'b1;
			item.kind     = KIND_HEADER;
			item.cnt      = 4'd1;
			item.width    = w_q;
			item.height   = h_q;
			item.bpp      = bpp_q;
			item.top      = top_q;
			n_phase       = PH_PIX;
			n_rb  = '0; n_col = '0; n_row = '0; n_cb = '0; n_bip = '0;
		end

		if (n_phase == PH_PIX || n_phase == PH_DONE || n_phase == PH_ERR) n_pos = eff_pos;
		else n_pos = eff_pos + 32'd1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q  <= 13'd2048;
			max_height_q <= 13'd3072;
			phase_q      <= PH_HDR;
			pos_q        <= '0;
			fa_q         <= '0;
			off_q        <= '0;
			raw_w_q      <= '0;
			raw_h_q      <= '0;
			raw_bpp_q    <= '0;
			planes_ok_q  <= 1'b0;
			bpp_q        <= '0;
			w_q          <= '0;
			h_q          <= '0;
			top_q        <= 1'b0;
			pc_q         <= '0;
			rowlen_q     <= '0;
			rb_q         <= '0;
			row_q        <= '0;
			col_q        <= '0;
			bip_q        <= '0;
			cb_q         <= '0;
			s1_vld_q     <= 1'b0;
			s1_k_q       <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_MAX_WIDTH:  max_width_q  <= pwdata[12:0];
					REG_MAX_HEIGHT: max_height_q <= pwdata[12:0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= n_phase;  pos_q <= n_pos;   fa_q <= n_fa;    off_q <= n_off;
				raw_w_q <= n_raw_w;  raw_h_q <= n_raw_h; raw_bpp_q <= n_raw_bpp;
				planes_ok_q <= n_planes_ok; bpp_q <= n_bpp; w_q <= n_w; h_q <= n_h;
				top_q <= n_top;      pc_q <= n_pc;     rowlen_q <= n_rowlen;
				rb_q <= n_rb;        row_q <= n_row;   col_q <= n_col;
				bip_q <= n_bip;      cb_q <= n_cb;
				s1_vld_q <= item_vld;
				s1_k_q   <= '0;
			end else if (out_load) begin
				// step to the next pixel of this byte, drop the item after its last
				s1_k_q <= s1_k_q + 3'd1;
				if (s1_done) s1_vld_q <= 1'b0;
			end
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// palette memory and item payload
	always_ff @(posedge clk) begin
		if (accept && pal_we) begin
			pal_mem[pal_widx[AW-1:0]] <= pal_wdata;
			if (pal_widx < 8'd4) lut_q[pal_widx[1:0]] <= pal_wdata;
		end
		if (accept) begin
			pal_rd_s1 <= pal_mem[b[AW-1:0]];
			s1_q      <= item;
		end
	end

	// result stage
	logic [12:0] xk;
	logic [7:0]  sh1, sh2;
	logic [1:0]  idx2;
	logic [7:0]  small_lum, lum;
	logic        re;

	always_comb begin
		xk   = s1_q.xbase + 13'(s1_k_q);
		sh1  = s1_q.data << s1_k_q;
		sh2  = s1_q.data << {s1_k_q[1:0], 1'b0};
		idx2 = (s1_q.mode == PM_1BPP) ? {1'b0, sh1[7]} : sh2[7:6];
		small_lum = ({1'b0, idx2} < s1_q.pc_cap) ? lut_q[idx2] : {6'd0, idx2};
		case (s1_q.mode) inside
			PM_1BPP, PM_2BPP: lum = small_lum;
			PM_8BPP:          lum = s1_q.use_pal ? pal_rd_s1 : s1_q.data;
			default:          lum = luma3(s1_q.rgb[23:16], s1_q.rgb[15:8], s1_q.rgb[7:0]);
		endcase
		re = (14'(xk) + 14'd1 == 14'(s1_q.width));
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= s1_q.kind;
			m_tlast <= ({1'b0, s1_k_q} + 4'd1 == s1_q.cnt);
			m_tdata <= '0;
			case (s1_q.kind)
				KIND_PIXEL: begin
					m_tdata[7:0]   <= lum;
					m_tdata[19:8]  <= xk[11:0];
					m_tdata[31:20] <= s1_q.row[11:0];
					m_tdata[69]    <= re;
					m_tdata[70]    <= re && s1_q.last_row;
				end
				KIND_HEADER: begin
					m_tdata[48:36] <= s1_q.width;
					m_tdata[61:49] <= s1_q.height;
					m_tdata[67:62] <= s1_q.bpp;
					m_tdata[68]    <= s1_q.top;
				end
				default: m_tdata[35:32] <= s1_q.err;
			endcase
		end
	end

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> ({1'b0, s1_k_q} < s1_q.cnt))
		else $error("item sub-index past its result count");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_DONE && !s_tuser[0]) |=> !s1_vld_q)
		else $error("byte after image end produced a result");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_ERROR) |-> (m_tdata[35:32] != ERR_NONE && m_tlast))
		else $error("error result without code or not last");

	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_HEADER) |-> m_tlast)
		else $error("header result not last");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Byte-stream BMP decoder check: whole and broken files go in as transactions;
// every result is predicted at input acceptance and compared in order.
module testbench;
	import bmpl_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  lum;
		logic [11:0] px;
		logic [11:0] py;
		logic [3:0]  err;
		logic [12:0] w;
		logic [12:0] h;
		logic [5:0]  bpp;
		logic        top;
		logic        re;
		logic        ie;
		logic        last;
	} luma_res_t;

	typedef struct {
		logic [7:0] b;
		logic       first;
	} file_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	bmp_stream_to_luma_decoder u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	file_byte_t byte_q[$];
	luma_res_t  luma_expect[$];
	int         mismatches = 0;
	int         choke_left = 0;
	bit         in_taken = 0;
	int         send_gap = 0;
	int         recv_gap = 0;

	// decoder shadow state
	phase_t      ph;
	logic [31:0] bpos, fasm, poff, sw, sh, sbpp, stop, pcount, rlen, rbc;
	logic [31:0] col, rw, cbytes, bip, raw_w, raw_h, raw_bpp;
	bit          planes_ok;
	logic [7:0]  pal[256];
	logic [31:0] lim_w = 2048, lim_h = 3072;
	int          nres;

	function automatic logic [31:0] luma_of(logic [31:0] c);
		return ((32'd77 * c[23:16] + 32'd150 * c[15:8] + 32'd29 * c[7:0]) >> 8) & 32'hFF;
	endfunction

	function automatic logic [7:0] pal_value(logic [31:0] idx);
		if (idx < pcount && idx < 256) return pal[idx[7:0]];
		return idx[7:0];
	endfunction

	function automatic luma_res_t blank(logic [1:0] k);
		luma_res_t r;
		r = '{default: '0};
		r.kind = k;
		return r;
	endfunction

	task automatic raise_err(logic [3:0] code);
		luma_res_t r;
		r = blank(KIND_ERROR);
		r.err = code;
		luma_expect.push_back(r);
		nres++;
		ph = PH_ERR;
	endtask

	task automatic header_ok();
		luma_res_t r;
		r = blank(KIND_HEADER);
		r.w = sw[12:0];
		r.h = sh[12:0];
		r.bpp = sbpp[5:0];
		r.top = stop[0];
		luma_expect.push_back(r);
		nres++;
		ph = PH_PIX;
		rbc = 0; col = 0; rw = 0; cbytes = 0; bip = 0;
	endtask

	task automatic end_of_header(logic [31:0] nxt);
		if (poff < nxt) raise_err(ERR_BEHIND);
		else if (poff == nxt) header_ok();
		else ph = PH_SKIP;
	endtask

	task automatic add_pixel(logic [7:0] lum, logic [31:0] x);
		luma_res_t r;
		r = blank(KIND_PIXEL);
		r.lum = lum;
		r.px = x[11:0];
		r.py = rw[11:0];
		r.re = (x + 1 == sw);
		r.ie = r.re && (rw + 1 == sh);
		luma_expect.push_back(r);
		nres++;
	endtask

	task automatic clear_parse();
		ph = PH_HDR; bpos = 0; fasm = 0; poff = 0; sw = 0; sh = 0; sbpp = 0; stop = 0;
		pcount = 0; rlen = 0; rbc = 0; col = 0; rw = 0; cbytes = 0; bip = 0;
		raw_w = 0; raw_h = 0; raw_bpp = 0; planes_ok = 0;
	endtask

	task automatic hdr_byte(logic [31:0] pos, logic [7:0] b);
		logic [31:0] f, hh, lw, lh;
		bit vb;
		fasm = (fasm >> 8) | ({24'd0, b} << 24);
		f = fasm;
		case (pos)
			POS_SIG: if (f[31:16] != BMP_MAGIC) raise_err(ERR_NOT_BMP);
			POS_OFFSET: poff = f;
			POS_DIB: if (f < DIB_MIN) raise_err(ERR_DIB_SMALL);
			POS_WIDTH: raw_w = f;
			POS_HEIGHT: raw_h = f;
			POS_PLANES: planes_ok = (f[31:16] == 16'd1);
			POS_BPP: raw_bpp = {16'd0, f[31:16]};
			POS_COMPR: begin
				vb = raw_bpp == 1 || raw_bpp == 2 || raw_bpp == 8 || raw_bpp == 24 ||
					raw_bpp == 32;
				if (!planes_ok) raise_err(ERR_PLANES);
				else if (!vb) raise_err(ERR_BPP);
				else if (!(f == 0 || (raw_bpp == 32 && f == 3))) raise_err(ERR_COMPRESS);
				else sbpp = raw_bpp;
			end
			POS_COLORS: begin
				lw = lim_w > 4096 ? 4096 : lim_w;
				lh = lim_h > 4096 ? 4096 : lim_h;
				hh = raw_h[31] ? 32'd0 - raw_h : raw_h;
				if (f > 256) raise_err(ERR_PALETTE);
				else if (raw_w == 0 || raw_w[31] || hh == 0 || hh[31]) raise_err(ERR_DIMS);
				else if (raw_w > lw || hh > lh) raise_err(ERR_TOO_LARGE);
				else begin
					pcount = f; sw = raw_w; sh = hh; stop = raw_h[31];
					rlen = (raw_w * sbpp + 31) / 32 * 4;
				end
			end
			POS_HDR_END: begin
				if (pcount == 0) end_of_header(PAL_START);
				else ph = PH_PAL;
			end
			default: ;
		endcase
	endtask

	task automatic pix_byte(logic [7:0] b);
		logic [31:0] x, bpb, rb;
		rb = rbc;
		if (sbpp == 1) begin
			for (int k = 0; k < 8; k++) begin
				x = rb * 8 + k;
				if (x < sw) add_pixel(pal_value(b[7 - k]), x);
			end
		end else if (sbpp == 2) begin
			for (int k = 0; k < 4; k++) begin
				x = rb * 4 + k;
				if (x < sw) add_pixel(pal_value((b >> (6 - 2 * k)) & 3), x);
			end
		end else if (sbpp == 8) begin
			if (rb < sw) add_pixel(pal_value(b), rb);
		end else begin
			bpb = sbpp / 8;
			if (rb < sw * bpb) begin
				bip = rb % bpb;
				col = rb / bpb;
				if (bip < 3) begin
					cbytes = (cbytes & ~(32'hFF << (8 * bip))) | ({24'd0, b} << (8 * bip));
				end
				if (bip == 2) add_pixel(luma_of(cbytes), col);
			end
		end
		rbc = rb + 1;
		if (rbc >= rlen) begin
			rbc = 0;
			rw++;
			if (rw >= sh) ph = PH_DONE;
		end
	endtask

	// advance the shadow decoder by one accepted byte
	task automatic decode_byte(logic [7:0] b, logic first);
		logic [31:0] pos, rel;
		nres = 0;
		if (first) clear_parse();
		pos = bpos;
		case (ph)
			PH_HDR: hdr_byte(pos, b);
			PH_PAL: begin
				rel = pos - PAL_START;
				if (rel[1:0] < 3) begin
					cbytes = (cbytes & ~(32'hFF << (8 * rel[1:0]))) |
						({24'd0, b} << (8 * rel[1:0]));
				end else begin
					if ((rel >> 2) < 256) pal[rel[9:2]] = luma_of(cbytes);
					if ((rel >> 2) + 1 >= pcount) end_of_header(pos + 1);
				end
			end
			PH_SKIP: if (pos + 1 == poff) header_ok();
			PH_PIX: pix_byte(b);
			default: ;
		endcase
		if (ph != PH_PIX && ph != PH_DONE && ph != PH_ERR) bpos = pos + 1;
		if (nres > 0) luma_expect[$].last = 1'b1;
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender: present the oldest pending byte, drop valid during gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= byte_q[0].b;
				s_tuser <= byte_q[0].first;
				send_gap <= rand_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: long hold-off when requested, else random stalls
	always @(negedge clk) begin
		if (choke_left > 0) begin
			choke_left <= choke_left - 1;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if (arst_n) begin
			m_tready <= 1'b1;
			if (m_tready) recv_gap <= rand_gap();
		end
	end

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		luma_res_t e;
		in_taken = s_tvalid && s_tready;
		if (in_taken) begin
			decode_byte(byte_q[0].b, byte_q[0].first);
			void'(byte_q.pop_front());
		end
		if (m_tvalid && m_tready) begin
			if (luma_expect.size() == 0) begin
				flag_mismatch("unexpected result kind", m_tuser, 0);
			end else begin
				e = luma_expect.pop_front();
				if (m_tuser != e.kind) flag_mismatch("kind", m_tuser, e.kind);
				if (m_tdata[7:0] != e.lum) flag_mismatch("lum", m_tdata[7:0], e.lum);
				if (m_tdata[19:8] != e.px) flag_mismatch("pixel_x", m_tdata[19:8], e.px);
				if (m_tdata[31:20] != e.py) flag_mismatch("pixel_y", m_tdata[31:20], e.py);
				if (m_tdata[35:32] != e.err) flag_mismatch("error", m_tdata[35:32], e.err);
				if (m_tdata[48:36] != e.w) flag_mismatch("width", m_tdata[48:36], e.w);
				if (m_tdata[61:49] != e.h) flag_mismatch("height", m_tdata[61:49], e.h);
				if (m_tdata[67:62] != e.bpp) flag_mismatch("bpp", m_tdata[67:62], e.bpp);
				if (m_tdata[68] != e.top) flag_mismatch("top_down", m_tdata[68], e.top);
				if (m_tdata[69] != e.re) flag_mismatch("row_end", m_tdata[69], e.re);
				if (m_tdata[70] != e.ie) flag_mismatch("image_end", m_tdata[70], e.ie);
				if (m_tdata[71] != 1'b0) flag_mismatch("spare bit", m_tdata[71], 0);
				if (m_tlast != e.last) flag_mismatch("last", m_tlast, e.last);
			end
		end
	end

	task automatic cfg_write(logic idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = idx == REG_MAX_WIDTH ? 3'd0 : 3'd4;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (idx == REG_MAX_WIDTH) lim_w = val & 32'h1FFF;
		else lim_h = val & 32'h1FFF;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// hold until every byte is in and every result is out, then let the block drain
	task automatic settle();
		do @(posedge clk); while (byte_q.size() != 0 || luma_expect.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic put32(ref logic [7:0] f[$], input logic [31:0] v);
		for (int i = 0; i < 4; i++) f.push_back(v[8 * i +: 8]);
	endtask

	// build one file; corrupt_at >= 0 overwrites one byte, cut > 0 truncates
	task automatic send_file(logic [15:0] sig, logic [31:0] dib, logic [31:0] w,
		logic [31:0] h, logic [15:0] planes, logic [15:0] bpp, logic [31:0] compr,
		logic [31:0] colors, int off_extra, int corrupt_at = -1, int cut = 0);
		logic [7:0]  f[$];
		logic [31:0] hh;
		int npal, nbody, off;
		npal = colors <= 256 ? colors : 0;
		off = 54 + 4 * npal + off_extra;
		hh = h[31] ? 32'd0 - h : h;
		nbody = (w <= 4096 && hh <= 4096) ? (w * bpp + 31) / 32 * 4 * hh : 16;
		if (nbody > 6000) nbody = 16;
		f.push_back(sig[7:0]); f.push_back(sig[15:8]);
		put32(f, $urandom); put32(f, $urandom); put32(f, off);
		put32(f, dib); put32(f, w); put32(f, h);
		f.push_back(planes[7:0]); f.push_back(planes[15:8]);
		f.push_back(bpp[7:0]); f.push_back(bpp[15:8]);
		put32(f, compr);
		repeat (12) f.push_back($urandom);
		put32(f, colors); put32(f, $urandom);
		repeat (4 * npal) f.push_back($urandom);
		while (f.size() < off) f.push_back($urandom);
		repeat (nbody + $urandom_range(0, 3)) f.push_back($urandom);
		if (corrupt_at >= 0 && corrupt_at < f.size()) f[corrupt_at] = $urandom;
		if (cut > 0 && cut < f.size()) f = f[0:cut - 1];
		foreach (f[i]) byte_q.push_back('{b: f[i], first: i == 0});
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		clear_parse();

		// header checks cut short after the failing byte: signature, info size,
		// offset behind the header
		send_file(16'h4D43, 40, 4, 2, 1, 8, 0, 0, 0, -1, 3);
		send_file(BMP_MAGIC, 39, 4, 2, 1, 8, 0, 0, 0, -1, 19);
		send_file(BMP_MAGIC, 40, 4, 2, 1, 8, 0, 0, -2, -1, 56);
		// accepted images: 2 bpp with skipped gap, top-down 32 bpp, 8 bpp with
		// indexes past the palette
		send_file(BMP_MAGIC, 40, 7, 1, 1, 2, 0, 2, 2);
		send_file(BMP_MAGIC, 40, 3, -32'sd1, 1, 32, 3, 0, 1);
		send_file(BMP_MAGIC, 40, 3, 1, 1, 8, 0, 3, 0);
		settle();

		// tight width limit, then limits above the ceiling
		cfg_write(REG_MAX_WIDTH, 2);
		send_file(BMP_MAGIC, 40, 3, 1, 1, 8, 0, 0, 0, -1, 51);
		settle();
		cfg_write(REG_MAX_WIDTH, 8191);
		cfg_write(REG_MAX_HEIGHT, 8191);

		// receiver stalls long while 1-bpp bytes keep coming
		choke_left = 400;
		send_file(BMP_MAGIC, 40, 12, 2, 1, 1, 0, 2, 0);
		settle();

		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
